[hw/rtl/bftr_pkg.sv]
// Shared definitions for the bitmap font text rasterizer: screen limits,
// the 5x7 glyph ROM, the color palette and the job record between stages.
// No dependencies.
package bftr_pkg;

    // Screen geometry and text layout.
    localparam int SCREEN_WIDTH  = 960;
    localparam int SCREEN_HEIGHT = 544;
    localparam int CHAR_STEP     = 12;
    localparam int LINE_STEP     = 18;
    localparam int GLYPH_W       = 5;
    localparam int GLYPH_H       = 7;
    localparam int ROW_RUNS      = 2 * GLYPH_H;
    localparam int MASK_W        = 2 * GLYPH_W;
    localparam int RUN_IDX_W     = $clog2(ROW_RUNS);
    localparam int CURSOR_MAX    = 1023;
    localparam int EDGE_MARGIN   = 4;

    // Character codes with a special meaning.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Color codes.
    localparam logic [1:0] COLOR_INFO  = 2'd0;
    localparam logic [1:0] COLOR_OK    = 2'd1;
    localparam logic [1:0] COLOR_WARN  = 2'd2;
    localparam logic [1:0] COLOR_ERROR = 2'd3;

    // Glyph rows, top row at index 0; bit 4 is the leftmost pixel.
    typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_t;

    // One drawn character, handed from the control stage to the emitter.
    typedef struct packed {
        logic signed [10:0]               x;
        logic signed [10:0]               y;
        logic [GLYPH_H-1:0][MASK_W-1:0]   masks;
        logic [ROW_RUNS-1:0]              runs;
        logic [1:0]                       color;
    } job_t;

    // Character generator ROM; bytes without a glyph show a question mark.
    function automatic glyph_t glyph_rows(input logic [7:0] ch);
        glyph_t rows;
        case (ch)
            8'h41: rows = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
            8'h42: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}; // B
            8'h43: rows = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}; // C
            8'h44: rows = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}; // D
            8'h45: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // E
            8'h46: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}; // F
            8'h47: rows = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F}; // G
            8'h48: rows = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // H
            8'h49: rows = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // I
            8'h4A: rows = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E}; // J
            8'h4B: rows = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}; // K
            8'h4C: rows = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // L
            8'h4D: rows = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
            8'h4E: rows = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}; // N
            8'h4F: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // O
            8'h50: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // P
            8'h51: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D}; // Q
            8'h52: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // R
            8'h53: rows = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}; // S
            8'h54: rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
            8'h55: rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // U
            8'h56: rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}; // V
            8'h57: rows = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A}; // W
            8'h58: rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11}; // X
            8'h59: rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
            8'h5A: rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}; // Z
            8'h30: rows = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
            8'h31: rows = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 1
            8'h32: rows = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // 2
            8'h33: rows = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}; // 3
            8'h34: rows = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // 4
            8'h35: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}; // 5
            8'h36: rows = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // 6
            8'h37: rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
            8'h38: rows = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // 8
            8'h39: rows = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}; // 9
            8'h2D: rows = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // -
            8'h3A: rows = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // :
            8'h2E: rows = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04}; // .
            8'h2F: rows = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10}; // /
            8'h3D: rows = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00}; // =
            8'h5F: rows = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F}; // _
            8'h5B: rows = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E}; // [
            8'h5D: rows = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E}; // ]
            8'h25: rows = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13}; // %
            default: rows = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04}; // ?
        endcase
        return rows;
    endfunction

    // Doubles each glyph pixel horizontally into a 10-pixel mask.
    function automatic logic [MASK_W-1:0] widen_row(input logic [GLYPH_W-1:0] bits);
        logic [MASK_W-1:0] mask;
        mask = '0;
        for (int c = 0; c < GLYPH_W; c++) begin
            mask[2*c]   = bits[c];
            mask[2*c+1] = bits[c];
        end
        return mask;
    endfunction

    // ABGR color word for each color code.
    function automatic logic [31:0] palette(input logic [1:0] code);
        logic [31:0] word;
        case (code)
            COLOR_INFO:  word = 32'hFFFF_FFFF;
            COLOR_OK:    word = 32'hFF80_FF80;
            COLOR_WARN:  word = 32'hFF00_FFFF;
            COLOR_ERROR: word = 32'hFF00_00FF;
            default:     word = 32'hFFFF_FFFF;
        endcase
        return word;
    endfunction

endpackage

[hw/rtl/bftr_ctrl.sv]
// Text cursor state and character decode: updates cursor, line origin,
// color and stop flag per accepted transaction and builds the row-run job.
// Depends on bftr_pkg.
module bftr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                start_req,
    input  logic signed [10:0]  start_x,
    input  logic signed [10:0]  start_y,
    input  logic [1:0]          color_code,
    input  logic [7:0]          character,
    output logic                job_load,
    output bftr_pkg::job_t      job
);

    logic signed [10:0] cursor_x_reg, cursor_x_next;
    logic signed [10:0] cursor_y_reg, cursor_y_next;
    logic signed [10:0] origin_x_reg, origin_x_next;
    logic [1:0]         color_reg, color_next;
    logic               stopped_reg, stopped_next;

    // Cursor, origin, color and stop flag registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            origin_x_reg <= '0;
            color_reg    <= bftr_pkg::COLOR_INFO;
            stopped_reg  <= 1'b1;
        end else begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            origin_x_reg <= origin_x_next;
            color_reg    <= color_next;
            stopped_reg  <= stopped_next;
        end
    end

    // Character handling and job construction for one transaction.
    always_comb begin
        logic signed [10:0] cx;
        logic signed [10:0] cy;
        logic signed [10:0] ox;
        logic [1:0]         col;
        logic               stop;
        logic signed [11:0] y_step;
        logic signed [12:0] x_lim;
        logic signed [12:0] y_lim;
        logic               at_limit;
        logic [7:0]         ch_fold;
        logic               draw;
        logic signed [11:0] px;
        logic signed [11:0] py;
        logic [bftr_pkg::MASK_W-1:0] clip;
        bftr_pkg::glyph_t   glyph;

        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        origin_x_next = origin_x_reg;
        color_next    = color_reg;
        stopped_next  = stopped_reg;

        // A start transaction loads the origin before its own character.
        if (start_req) begin
            cx   = start_x;
            cy   = start_y;
            ox   = start_x;
            col  = color_code;
            stop = 1'b0;
        end else begin
            cx   = cursor_x_reg;
            cy   = cursor_y_reg;
            ox   = origin_x_reg;
            col  = color_reg;
            stop = stopped_reg;
        end

        y_step   = $signed({cy[10], cy}) + $signed(12'(bftr_pkg::LINE_STEP));
        x_lim    = $signed({{2{cx[10]}}, cx}) + $signed(13'(bftr_pkg::CHAR_STEP));
        y_lim    = $signed({{2{cy[10]}}, cy}) + $signed(13'(bftr_pkg::ROW_RUNS));
        at_limit = (x_lim >= $signed(13'(bftr_pkg::SCREEN_WIDTH - bftr_pkg::EDGE_MARGIN)))
                || (y_lim >= $signed(13'(bftr_pkg::SCREEN_HEIGHT - bftr_pkg::EDGE_MARGIN)));

        // Fold lower case to upper case.
        if (character >= bftr_pkg::CHAR_LOWER_A && character <= bftr_pkg::CHAR_LOWER_Z) begin
            ch_fold = character - bftr_pkg::CASE_OFFSET;
        end else begin
            ch_fold = character;
        end

        draw = 1'b0;
        if (accept) begin
            cursor_x_next = cx;
            cursor_y_next = cy;
            origin_x_next = ox;
            color_next    = col;
            stopped_next  = stop;
            if (!stop && character != bftr_pkg::CHAR_NUL) begin
                if (character == bftr_pkg::CHAR_NEWLINE) begin
                    if (y_step > $signed(12'(bftr_pkg::CURSOR_MAX))) begin
                        cursor_y_next = 11'(bftr_pkg::CURSOR_MAX);
                    end else begin
                        cursor_y_next = y_step[10:0];
                    end
                    cursor_x_next = ox;
                end else if (at_limit) begin
                    stopped_next = 1'b1;
                end else begin
                    draw          = (ch_fold != bftr_pkg::CHAR_SPACE);
                    cursor_x_next = x_lim[10:0];
                end
            end
        end

        // Columns of the 10-pixel mask that fall on the screen.
        for (int i = 0; i < bftr_pkg::MASK_W; i++) begin
            px = $signed({cx[10], cx}) + $signed(12'(i));
            clip[bftr_pkg::MASK_W-1-i] = !px[11]
                && (px < $signed(12'(bftr_pkg::SCREEN_WIDTH)));
        end

        glyph = bftr_pkg::glyph_rows(ch_fold);
        for (int r = 0; r < bftr_pkg::GLYPH_H; r++) begin
            job.masks[r] = bftr_pkg::widen_row(glyph[r]) & clip;
        end

        // A run is emitted when its row is on screen and its mask is not empty.
        for (int k = 0; k < bftr_pkg::ROW_RUNS; k++) begin
            py = $signed({cy[10], cy}) + $signed(12'(k));
            job.runs[k] = !py[11] && (py < $signed(12'(bftr_pkg::SCREEN_HEIGHT)))
                && (|job.masks[k/2]);
        end

        job.x     = cx;
        job.y     = cy;
        job.color = col;
        job_load  = draw && (|job.runs);
    end

endmodule

[hw/rtl/bftr_emit.sv]
// Row-run emitter: holds one character job and sends its visible row runs,
// top to bottom, through a registered output stage.
// Depends on bftr_pkg.
module bftr_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_load,
    input  bftr_pkg::job_t      job,
    output logic                job_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [9:0]          m_row_y,
    output logic signed [10:0]  m_row_x,
    output logic [9:0]          m_pixel_mask,
    output logic [31:0]         m_pixel_color,
    output logic                m_last
);

    logic [bftr_pkg::ROW_RUNS-1:0]                  runs_reg, runs_next;
    logic signed [10:0]                             x_reg;
    logic signed [10:0]                             y_reg;
    logic [bftr_pkg::GLYPH_H-1:0][bftr_pkg::MASK_W-1:0] masks_reg;
    logic [1:0]                                     color_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [9:0]             m_row_y_reg, m_row_y_next;
    logic signed [10:0]     m_row_x_reg, m_row_x_next;
    logic [9:0]             m_pixel_mask_reg, m_pixel_mask_next;
    logic [31:0]            m_pixel_color_reg, m_pixel_color_next;
    logic                   m_last_reg, m_last_next;

    logic [bftr_pkg::ROW_RUNS-1:0]  low_run;
    logic [bftr_pkg::ROW_RUNS-1:0]  rest_runs;
    logic [bftr_pkg::RUN_IDX_W-1:0] run_idx;
    logic                           advance;
    logic                           pop;
    logic signed [11:0]             run_y;

    // Pick the topmost pending run.
    always_comb begin
        low_run   = runs_reg & (~runs_reg + 1'b1);
        rest_runs = runs_reg & ~low_run;
        run_idx   = '0;
        for (int k = 0; k < bftr_pkg::ROW_RUNS; k++) begin
            if (low_run[k]) begin
                run_idx = bftr_pkg::RUN_IDX_W'(k);
            end
        end
    end

    // Output stage moves when empty or when its transaction completes.
    assign advance   = !m_valid_reg || m_ready;
    assign pop       = advance && (|runs_reg);
    assign job_ready = !(|runs_reg) || (pop && !(|rest_runs));
    assign run_y     = $signed({y_reg[10], y_reg}) + $signed(12'(run_idx));

    always_comb begin
        runs_next          = runs_reg;
        m_valid_next       = m_valid_reg;
        m_row_y_next       = m_row_y_reg;
        m_row_x_next       = m_row_x_reg;
        m_pixel_mask_next  = m_pixel_mask_reg;
        m_pixel_color_next = m_pixel_color_reg;
        m_last_next        = m_last_reg;
        if (advance) begin
            m_valid_next = |runs_reg;
        end
        if (pop) begin
            runs_next          = rest_runs;
            m_row_y_next       = run_y[9:0];
            m_row_x_next       = x_reg;
            m_pixel_mask_next  = masks_reg[run_idx[bftr_pkg::RUN_IDX_W-1:1]];
            m_pixel_color_next = bftr_pkg::palette(color_reg);
            m_last_next        = !(|rest_runs);
        end
        if (job_load) begin
            runs_next = job.runs;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            runs_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            runs_reg    <= runs_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Job and result payload registers.
    always_ff @(posedge aclk) begin
        if (job_load) begin
            x_reg     <= job.x;
            y_reg     <= job.y;
            masks_reg <= job.masks;
            color_reg <= job.color;
        end
        m_row_y_reg       <= m_row_y_next;
        m_row_x_reg       <= m_row_x_next;
        m_pixel_mask_reg  <= m_pixel_mask_next;
        m_pixel_color_reg <= m_pixel_color_next;
        m_last_reg        <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_row_y       = m_row_y_reg;
    assign m_row_x       = m_row_x_reg;
    assign m_pixel_mask  = m_pixel_mask_reg;
    assign m_pixel_color = m_pixel_color_reg;
    assign m_last        = m_last_reg;

endmodule

[hw/rtl/bitmap_font_text_rasterizer.sv]
// A character's runs pass from the emitter's job registers into its output stage.
// One row run per cycle while m_ready does not stall the output; a character has
// up to 14 visible runs, and one that draws nothing never occupies the emitter.
// The next character is taken in the cycle its predecessor's last run moves into the output stage.
// Reset (aresetn low, synchronous) clears the cursor and color and sets the stop flag.
// Depends on bftr_pkg, bftr_ctrl and bftr_emit.
module bitmap_font_text_rasterizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_start_req,
    input  logic signed [10:0]  s_start_x,
    input  logic signed [10:0]  s_start_y,
    input  logic [1:0]          s_color_code,
    input  logic [7:0]          s_character,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [9:0]          m_row_y,
    output logic signed [10:0]  m_row_x,
    output logic [9:0]          m_pixel_mask,
    output logic [31:0]         m_pixel_color,
    output logic                m_last
);

    logic           accept;
    logic           job_load;
    logic           job_ready;
    bftr_pkg::job_t job;

    // An input transaction completes when the emitter can take a new job.
    assign s_ready = job_ready;
    assign accept  = s_valid && job_ready;

    bftr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .start_req  (s_start_req),
        .start_x    (s_start_x),
        .start_y    (s_start_y),
        .color_code (s_color_code),
        .character  (s_character),
        .job_load   (job_load),
        .job        (job)
    );

    bftr_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_load      (job_load),
        .job           (job),
        .job_ready     (job_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_y       (m_row_y),
        .m_row_x       (m_row_x),
        .m_pixel_mask  (m_pixel_mask),
        .m_pixel_color (m_pixel_color),
        .m_last        (m_last)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_font_text_rasterizer: character transactions go in,
// screen row runs come out and are checked against a predictor of the rasterizer.
// Depends on bftr_pkg and the rasterizer RTL.
module testbench;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE_CYCLES = 20;

    // One character transaction as queued for the driver.
    typedef struct {
        logic               start_req;
        logic signed [10:0] start_x;
        logic signed [10:0] start_y;
        logic [1:0]         color_code;
        logic [7:0]         character;
        bit                 drain;
    } text_item_t;

    // One screen row run as seen on the result channel.
    typedef struct {
        logic [9:0]         row_y;
        logic signed [10:0] row_x;
        logic [9:0]         pixel_mask;
        logic [31:0]        pixel_color;
        logic               last;
    } row_run_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_start_req = 1'b0;
    logic signed [10:0] s_start_x = '0;
    logic signed [10:0] s_start_y = '0;
    logic [1:0]         s_color_code = '0;
    logic [7:0]         s_character = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [9:0]         m_row_y;
    logic signed [10:0] m_row_x;
    logic [9:0]         m_pixel_mask;
    logic [31:0]        m_pixel_color;
    logic               m_last;

    text_item_t pending_q[$];
    row_run_t   row_run_q[$];
    text_item_t held_item;
    int         errors = 0;
    int         cycle_count = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    bit         calm = 1'b0;

    // Predictor state: pen position, left margin, ink and the stop flag.
    logic signed [10:0] pen_x = '0;
    logic signed [10:0] pen_y = '0;
    logic signed [10:0] margin_x = '0;
    logic [1:0]         ink = bftr_pkg::COLOR_INFO;
    bit                 halted = 1'b1;

    bitmap_font_text_rasterizer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_req   (s_start_req),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_color_code  (s_color_code),
        .s_character   (s_character),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_y       (m_row_y),
        .m_row_x       (m_row_x),
        .m_pixel_mask  (m_pixel_mask),
        .m_pixel_color (m_pixel_color),
        .m_last        (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The 5x7 font, top row in the upper five bits; bit 4 of a row is its leftmost pixel.
    function automatic logic [34:0] font_bits(input logic [7:0] ch);
        case (ch)
            "A": return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            "E": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": return {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            "H": return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": return {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "J": return {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
            "K": return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "Q": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            "R": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "W": return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            "X": return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            "Y": return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            "0": return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2": return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3": return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "4": return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "5": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            "6": return {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9": return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
            "-": return {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            ":": return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
            ".": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04};
            "/": return {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
            "=": return {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
            "_": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
            "[": return {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
            "]": return {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
            "%": return {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
            default: return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
        endcase
    endfunction

    function automatic logic [31:0] ink_word(input logic [1:0] code);
        case (code)
            bftr_pkg::COLOR_OK:    return 32'hFF80_FF80;
            bftr_pkg::COLOR_WARN:  return 32'hFF00_FFFF;
            bftr_pkg::COLOR_ERROR: return 32'hFF00_00FF;
            default:               return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Works out the row runs one accepted character produces and updates the pen.
    task automatic raster_character(input text_item_t it);
        logic [7:0]  ch;
        logic [34:0] glyph;
        logic [4:0]  bits;
        logic [9:0]  clip;
        logic [9:0]  mask;
        int          cx;
        int          cy;
        int          py;
        row_run_t    run;
        row_run_t    runs[$];
        ch = it.character;
        if (it.start_req) begin
            pen_x = it.start_x;
            pen_y = it.start_y;
            margin_x = it.start_x;
            ink = it.color_code;
            halted = 1'b0;
        end
        if (halted || ch == bftr_pkg::CHAR_NUL)
            return;
        cx = pen_x;
        cy = pen_y;
        if (ch == bftr_pkg::CHAR_NEWLINE) begin
            cy = cy + bftr_pkg::LINE_STEP;
            if (cy > bftr_pkg::CURSOR_MAX)
                cy = bftr_pkg::CURSOR_MAX;
            pen_y = cy[10:0];
            pen_x = margin_x;
            return;
        end
        if (cx + bftr_pkg::CHAR_STEP >= bftr_pkg::SCREEN_WIDTH - bftr_pkg::EDGE_MARGIN ||
            cy + 2 * bftr_pkg::GLYPH_H >= bftr_pkg::SCREEN_HEIGHT - bftr_pkg::EDGE_MARGIN) begin
            halted = 1'b1;
            return;
        end
        if (ch >= bftr_pkg::CHAR_LOWER_A && ch <= bftr_pkg::CHAR_LOWER_Z)
            ch = ch - bftr_pkg::CASE_OFFSET;
        if (ch != bftr_pkg::CHAR_SPACE) begin
            // Columns off either side of the screen are masked out.
            clip = '0;
            for (int i = 0; i < 10; i++) begin
                if (cx + i >= 0 && cx + i < bftr_pkg::SCREEN_WIDTH)
                    clip[9 - i] = 1'b1;
            end
            glyph = font_bits(ch);
            for (int r = 0; r < bftr_pkg::GLYPH_H; r++) begin
                bits = glyph[34 - 5 * r -: 5];
                mask = '0;
                for (int k = 0; k < 5; k++)
                    mask[2 * k +: 2] = {2{bits[k]}};
                mask = mask & clip;
                if (mask == '0)
                    continue;
                // Each glyph row covers two screen rows.
                for (int s = 0; s < 2; s++) begin
                    py = cy + 2 * r + s;
                    if (py < 0 || py >= bftr_pkg::SCREEN_HEIGHT)
                        continue;
                    run.row_y = py[9:0];
                    run.row_x = pen_x;
                    run.pixel_mask = mask;
                    run.pixel_color = ink_word(ink);
                    run.last = 1'b0;
                    runs.push_back(run);
                end
            end
            if (runs.size() > 0)
                runs[runs.size() - 1].last = 1'b1;
            foreach (runs[j])
                row_run_q.push_back(runs[j]);
        end
        cx = cx + bftr_pkg::CHAR_STEP;
        pen_x = cx[10:0];
    endtask

    // Mostly back-to-back, sometimes a short gap, rarely a long gap.
    function automatic int idle_gap();
        int k;
        k = $urandom_range(0, 99);
        if (calm || k < 55)
            return 0;
        if (k < 88)
            return $urandom_range(1, 3);
        if (k < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic queue_item(input logic start, input int x, input int y,
                              input logic [1:0] color, input logic [7:0] ch,
                              input bit drain = 1'b0);
        text_item_t it;
        it.start_req = start;
        it.start_x = x[10:0];
        it.start_y = y[10:0];
        it.color_code = color;
        it.character = ch;
        it.drain = drain;
        pending_q.push_back(it);
    endtask

    function automatic logic [7:0] pick_character();
        string glyph_set;
        int    k;
        glyph_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-:./=_[]%";
        k = $urandom_range(0, 99);
        if (k < 45)
            return glyph_set[$urandom_range(0, glyph_set.len() - 1)];
        if (k < 65)
            return 8'(bftr_pkg::CHAR_LOWER_A + $urandom_range(0, 25));
        if (k < 78)
            return bftr_pkg::CHAR_SPACE;
        if (k < 86)
            return bftr_pkg::CHAR_NEWLINE;
        return 8'($urandom_range(1, 255));
    endfunction

    // Driver: predicts each accepted transaction, then presents the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                raster_character(held_item);
            if (!(s_valid && !s_ready)) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             !(pending_q[0].drain && row_run_q.size() != 0)) begin
                    held_item = pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_start_req <= held_item.start_req;
                    s_start_x <= held_item.start_x;
                    s_start_y <= held_item.start_y;
                    s_color_code <= held_item.color_code;
                    s_character <= held_item.character;
                    send_idle = idle_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted row run and stalls the result channel at random.
    always @(posedge aclk) begin
        row_run_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (row_run_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected row run y=%0d x=%0d mask=%b color=%h last=%b",
                             $time, m_row_y, m_row_x, m_pixel_mask, m_pixel_color, m_last);
                end else begin
                    want = row_run_q.pop_front();
                    if (m_row_y !== want.row_y || m_row_x !== want.row_x ||
                        m_pixel_mask !== want.pixel_mask ||
                        m_pixel_color !== want.pixel_color || m_last !== want.last) begin
                        errors++;
                        $display("%0t: row run mismatch: expected y=%0d x=%0d mask=%b",
                                 $time, want.row_y, want.row_x, want.pixel_mask,
                                 " color=%h last=%b", want.pixel_color, want.last);
                        $display("%0t:                   actual   y=%0d x=%0d mask=%b",
                                 $time, m_row_y, m_row_x, m_pixel_mask,
                                 " color=%h last=%b", m_pixel_color, m_last);
                    end
                end
            end
            if (recv_idle > 0) begin
                recv_idle--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_idle = idle_gap();
            end
        end
    end

    // Cycle limit, and now and then a stretch with no idling on either side.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count % 200 == 0)
            calm <= ($urandom_range(0, 2) == 0);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int         made;
        int         line_len;
        int         x;
        int         y;
        logic [1:0] color;
        // Characters before the first start are ignored, newlines too.
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, "A");
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, bftr_pkg::CHAR_NEWLINE);
        // A start with a zero byte only loads the origin.
        queue_item(1'b1, 0, 0, bftr_pkg::COLOR_INFO, bftr_pkg::CHAR_NUL);
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, "A");
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, "z");
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, 8'h80);
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, 8'hFF);
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, bftr_pkg::CHAR_SPACE);
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, "%");
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, bftr_pkg::CHAR_NEWLINE);
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_INFO, "?");
        // Fully clipped glyph at the most negative origin, then a partly clipped one.
        queue_item(1'b1, -1024, -1024, bftr_pkg::COLOR_ERROR, "H");
        queue_item(1'b1, -5, -6, bftr_pkg::COLOR_OK, "M");
        // Last position that still draws, then the limit stops the text.
        queue_item(1'b1, 943, 525, bftr_pkg::COLOR_WARN, "W");
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_WARN, "B");
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_WARN, "C");
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_WARN, bftr_pkg::CHAR_NEWLINE);
        queue_item(1'b1, 1023, 1023, bftr_pkg::COLOR_ERROR, "8");
        // Newlines near the bottom saturate the cursor row.
        queue_item(1'b1, 10, 1010, bftr_pkg::COLOR_OK, bftr_pkg::CHAR_NEWLINE);
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_OK, bftr_pkg::CHAR_NEWLINE);
        queue_item(1'b0, 0, 0, bftr_pkg::COLOR_OK, "Q");
        // Sender holds off until all row runs are out.
        queue_item(1'b1, 100, 200, bftr_pkg::COLOR_INFO, "G", 1'b1);
        queue_item(1'b0, -1, -1, bftr_pkg::COLOR_ERROR, "0");

        // Random text: mostly lines that start on screen, some noise.
        made = 0;
        while (made < 76) begin
            color = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 7) == 0) begin
                    x = $urandom_range(0, 2047) - 1024;
                    y = $urandom_range(0, 2047) - 1024;
                end else begin
                    x = $urandom_range(0, 880) - 30;
                    y = $urandom_range(0, 520) - 20;
                end
                queue_item(1'b1, x, y, color, pick_character(), made == 50);
                made++;
                line_len = $urandom_range(2, 12);
                for (int i = 0; i < line_len; i++) begin
                    queue_item(1'b0, $urandom_range(0, 2047), $urandom_range(0, 2047),
                               2'($urandom_range(0, 3)), pick_character());
                    made++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_item(1'b0, 0, 0, color, bftr_pkg::CHAR_NUL);
                    made++;
                end
            end else begin
                queue_item(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), color, 8'($urandom_range(0, 255)));
                made++;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_valid)
            @(negedge aclk);
        while (row_run_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
